/* rtl/core/pbs_pkg.sv */
// Shared types, register map and reset constants for the proximity beep sequencer.
package pbs_pkg;

  // Configuration register map (index = paddr[4:2])
  typedef enum logic [2:0] {
    REG_DIST_MIN   = 3'd0,
    REG_DIST_MAX   = 3'd1,
    REG_DELAY_MIN  = 3'd2,
    REG_DELAY_MAX  = 3'd3,
    REG_BEEP_ON    = 3'd4,
    REG_OCTAVE_BND = 3'd5,
    REG_FLUX_MIN   = 3'd6,
    REG_BASE_FREQ  = 3'd7
  } pbs_reg_e;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register reset values
  localparam logic [15:0] DIST_MIN_RST   = 16'd100;
  localparam logic [15:0] DIST_MAX_RST   = 16'd12000;
  localparam logic [15:0] DELAY_MIN_RST  = 16'd80;
  localparam logic [15:0] DELAY_MAX_RST  = 16'd800;
  localparam logic [15:0] BEEP_ON_RST    = 16'd60;
  localparam logic [15:0] OCTAVE_BND_RST = 16'd4000;
  localparam logic [14:0] FLUX_MIN_RST   = 15'd100;
  localparam logic [10:0] BASE_FREQ_RST  = 11'd220;

  localparam int unsigned MAX_BANDS_DEF = 8;
  localparam int unsigned SHIFT_W       = 3;

  // Shared divider geometry: left-aligned dividend, one quotient bit per cycle
  localparam int unsigned DVD_W  = 32;
  localparam int unsigned DVS_W  = 16;
  localparam int unsigned STEP_W = 6;

  typedef struct packed {
    logic [15:0] range_lo_mm;
    logic [15:0] range_hi_mm;
    logic [15:0] delay_min_ms;
    logic [15:0] delay_max_ms;
    logic [15:0] beep_len_ms;
    logic [15:0] band_width_mm;
    logic [14:0] flux_min;
    logic [10:0] base_freq_hz;
  } pbs_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } pbs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } pbs_div_rsp_t;

endpackage

/* rtl/core/proximity_beep_sequencer.sv */
// Proximity beep sequencer top level: reading filter, interval/band sequencer, beep timer.
//
// One request per poll tick. The tick's reading (or the last valid one) becomes a
// distance in mm. If that distance lies within [range_lo_mm, range_hi_mm], a 16x16
// multiply and three passes of one shared bit-serial divider produce the beep
// interval (32 steps), the octave band count (17 steps) and the band index
// (16 steps); the ON/OFF timer then updates from now_ms. The divider gives one
// quotient bit per cycle while busy; when the range is a single point the
// interval pass is skipped. An out-of-range request goes from S_IDLE straight to
// S_FINISH, with no multiply or divider pass. A previous result still stalled in
// the output register adds its stall cycles before the new result is written.
// in_stall_o is high while a request is in flight. The result sits in an output
// register, so the next request is accepted while the previous result still
// waits to be taken. Configuration sits on an APB port (registers at byte
// addresses 4*i, pready tied high); the user must see that it is written only
// while the block is idle, as the block itself does not enforce this.
module proximity_beep_sequencer #(
  parameter int unsigned MAX_BANDS = pbs_pkg::MAX_BANDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pbs_pkg::ADDR_W-1:0] paddr,
  input  logic [pbs_pkg::DATA_W-1:0] pwdata,
  output logic [pbs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [31:0]                now_ms_i,
  input  logic                       frame_ready_i,
  input  logic signed [15:0]         dist_cm_i,
  input  logic signed [15:0]         flux_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       tone_active_o,
  output logic [17:0]                tone_freq_hz_o,
  output logic [15:0]                distance_mm_o,
  output logic [15:0]                interval_ms_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BANDS + 1);
  localparam int unsigned SW    = pbs_pkg::SHIFT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_IDIV_GO,
    S_IDIV_WAIT,
    S_CDIV_GO,
    S_CDIV_WAIT,
    S_BDIV_GO,
    S_BDIV_WAIT,
    S_FINISH
  } state_e;

  pbs_pkg::pbs_cfg_t     cfg;
  pbs_pkg::pbs_div_req_t div_req;
  pbs_pkg::pbs_div_rsp_t div_rsp;

  pbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  state_e         state_q;
  // architectural state
  logic [31:0]    phase_start_q;
  logic           beep_on_q;
  logic [15:0]    held_mm_q;
  logic           have_valid_q;
  logic [15:0]    period_q;
  logic [SW-1:0]  shift_q;
  // per-request working registers
  logic [31:0]    now_q;
  logic [15:0]    dist_q;
  logic           range_q;
  logic [31:0]    prod_q;
  logic [CNT_W-1:0] count_q;
  // result register
  logic           out_valid_q;
  logic           tone_q;
  logic [17:0]    freq_q;
  logic [15:0]    dist_out_q;
  logic [15:0]    intv_q;

  // ---- reading filter (request acceptance) ----
  logic        accept;
  logic        frame_bad;
  logic [18:0] mm_full;
  logic [15:0] mm_sat;
  logic [15:0] dist_in;
  logic        in_range;

  assign accept    = in_valid_i && !in_stall_o;
  assign frame_bad = dist_cm_i[15] || (dist_cm_i == 16'sd0) ||
                     ($signed(flux_i) < $signed({1'b0, cfg.flux_min}));
  // cm * 10 = cm*8 + cm*2
  assign mm_full   = ({3'b000, dist_cm_i} << 3) + ({3'b000, dist_cm_i} << 1);
  assign mm_sat    = (|mm_full[18:16]) ? 16'hFFFF : mm_full[15:0];

  always_comb begin
    if (!frame_ready_i) begin
      dist_in = have_valid_q ? held_mm_q : 16'd0;
    end else if (frame_bad) begin
      dist_in = 16'd0;
    end else begin
      dist_in = mm_sat;
    end
  end

  assign in_range = (dist_in >= cfg.range_lo_mm) && (dist_in <= cfg.range_hi_mm);

  // ---- interval mapping operands ----
  logic        empty_span;
  logic        ascend;
  logic [15:0] span;
  logic [15:0] off;
  logic [15:0] ddelay;
  logic [31:0] prod_d;
  logic [31:0] idvd;
  logic [15:0] iq;
  logic [15:0] period_d;

  assign empty_span = cfg.range_hi_mm <= cfg.range_lo_mm;
  assign ascend     = cfg.delay_max_ms >= cfg.delay_min_ms;
  assign span       = cfg.range_hi_mm - cfg.range_lo_mm;
  assign off        = dist_q - cfg.range_lo_mm;
  assign ddelay     = ascend ? (cfg.delay_max_ms - cfg.delay_min_ms)
                             : (cfg.delay_min_ms - cfg.delay_max_ms);
  assign prod_d     = 32'(off) * 32'(ddelay);
  // falling interval rounds the quotient up so that the subtraction floors
  assign idvd       = ascend ? prod_q : (prod_q + 32'(span) - 32'd1);
  assign iq         = div_rsp.quotient[15:0];
  assign period_d   = ascend ? (cfg.delay_min_ms + iq) : (cfg.delay_min_ms - iq);

  // ---- octave band ----
  logic [15:0]      band_w;
  logic [16:0]      cdvd;
  logic [16:0]      cq;
  logic [CNT_W-1:0] count_d;
  logic [15:0]      bq;
  logic [CNT_W-1:0] band;
  logic [CNT_W-1:0] shift_full;

  assign band_w = (cfg.band_width_mm == 16'd0) ? 16'd1 : cfg.band_width_mm;
  assign cdvd   = 17'(cfg.range_hi_mm) + 17'(band_w) - 17'd1;
  assign cq     = div_rsp.quotient[16:0];

  always_comb begin
    if (cq == 17'd0) begin
      count_d = CNT_W'(1);
    end else if (cq > 17'(MAX_BANDS)) begin
      count_d = CNT_W'(MAX_BANDS);
    end else begin
      count_d = cq[CNT_W-1:0];
    end
  end

  assign bq         = div_rsp.quotient[15:0];
  assign band       = (bq >= 16'(count_q)) ? (count_q - CNT_W'(1)) : bq[CNT_W-1:0];
  assign shift_full = count_q - CNT_W'(1) - band;

  // ---- divider requests ----
  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_IDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = idvd;
        div_req.divisor  = span;
        div_req.steps    = pbs_pkg::STEP_W'(32);
      end
      S_CDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {cdvd, 15'd0};
        div_req.divisor  = band_w;
        div_req.steps    = pbs_pkg::STEP_W'(17);
      end
      S_BDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {dist_q, 16'd0};
        div_req.divisor  = band_w;
        div_req.steps    = pbs_pkg::STEP_W'(16);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // ---- beep timer (applied when the result is written) ----
  logic [31:0] elapsed;
  logic [15:0] gap;
  logic        beep_d;
  logic        restart;

  assign elapsed = now_q - phase_start_q;
  assign gap     = (period_q > cfg.beep_len_ms) ? (period_q - cfg.beep_len_ms) : 16'd0;

  always_comb begin
    beep_d  = beep_on_q;
    restart = 1'b0;
    if (range_q) begin
      if (!beep_on_q) begin
        if (elapsed >= 32'(gap)) begin
          beep_d  = 1'b1;
          restart = 1'b1;
        end
      end else if (elapsed >= 32'(cfg.beep_len_ms)) begin
        beep_d  = 1'b0;
        restart = 1'b1;
      end
    end else if (beep_on_q) begin
      beep_d  = 1'b0;
      restart = 1'b1;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---- sequencer: state and registered outputs ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_start_q <= '0;
      beep_on_q     <= 1'b0;
      held_mm_q     <= '0;
      have_valid_q  <= 1'b0;
      period_q      <= pbs_pkg::DELAY_MAX_RST;
      shift_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // a result taken while the next one is written is replaced in S_FINISH
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (frame_ready_i) begin
              have_valid_q <= !frame_bad;
              if (!frame_bad) begin
                held_mm_q <= mm_sat;
              end
            end
            state_q <= in_range ? S_MUL : S_FINISH;
          end
        end
        S_MUL: begin
          if (empty_span) begin
            period_q <= cfg.delay_min_ms;
            state_q  <= S_CDIV_GO;
          end else begin
            state_q <= S_IDIV_GO;
          end
        end
        S_IDIV_GO: begin
          state_q <= S_IDIV_WAIT;
        end
        S_IDIV_WAIT: begin
          if (div_rsp.done) begin
            period_q <= period_d;
            state_q  <= S_CDIV_GO;
          end
        end
        S_CDIV_GO: begin
          state_q <= S_CDIV_WAIT;
        end
        S_CDIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_BDIV_GO;
          end
        end
        S_BDIV_GO: begin
          state_q <= S_BDIV_WAIT;
        end
        S_BDIV_WAIT: begin
          if (div_rsp.done) begin
            shift_q <= SW'(shift_full);
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            beep_on_q   <= beep_d;
            if (restart) begin
              phase_start_q <= now_q;
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q   <= now_ms_i;
      dist_q  <= dist_in;
      range_q <= in_range;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if ((state_q == S_CDIV_WAIT) && div_rsp.done) begin
      count_q <= count_d;
    end
    if ((state_q == S_FINISH) && out_free) begin
      tone_q     <= beep_d;
      freq_q     <= 18'(cfg.base_freq_hz) << shift_q;
      dist_out_q <= dist_q;
      intv_q     <= period_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign tone_active_o  = tone_q;
  assign tone_freq_hz_o = freq_q;
  assign distance_mm_o  = dist_out_q;
  assign interval_ms_o  = intv_q;

endmodule

/* rtl/core/pbs_regs.sv */
// APB configuration register file for the proximity beep sequencer.
module pbs_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbs_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbs_pkg::DATA_W-1:0]   pwdata,
  output logic [pbs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output pbs_pkg::pbs_cfg_t            cfg_o
);

  pbs_pkg::pbs_cfg_t cfg_q;
  pbs_pkg::pbs_reg_e idx;
  logic              wr_en;

  assign idx    = pbs_pkg::pbs_reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_lo_mm   <= pbs_pkg::DIST_MIN_RST;
      cfg_q.range_hi_mm   <= pbs_pkg::DIST_MAX_RST;
      cfg_q.delay_min_ms  <= pbs_pkg::DELAY_MIN_RST;
      cfg_q.delay_max_ms  <= pbs_pkg::DELAY_MAX_RST;
      cfg_q.beep_len_ms   <= pbs_pkg::BEEP_ON_RST;
      cfg_q.band_width_mm <= pbs_pkg::OCTAVE_BND_RST;
      cfg_q.flux_min      <= pbs_pkg::FLUX_MIN_RST;
      cfg_q.base_freq_hz  <= pbs_pkg::BASE_FREQ_RST;
    end else if (wr_en) begin
      unique case (idx)
        pbs_pkg::REG_DIST_MIN:   cfg_q.range_lo_mm   <= pwdata[15:0];
        pbs_pkg::REG_DIST_MAX:   cfg_q.range_hi_mm   <= pwdata[15:0];
        pbs_pkg::REG_DELAY_MIN:  cfg_q.delay_min_ms  <= pwdata[15:0];
        pbs_pkg::REG_DELAY_MAX:  cfg_q.delay_max_ms  <= pwdata[15:0];
        pbs_pkg::REG_BEEP_ON:    cfg_q.beep_len_ms   <= pwdata[15:0];
        pbs_pkg::REG_OCTAVE_BND: cfg_q.band_width_mm <= pwdata[15:0];
        pbs_pkg::REG_FLUX_MIN:   cfg_q.flux_min      <= pwdata[14:0];
        pbs_pkg::REG_BASE_FREQ:  cfg_q.base_freq_hz  <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pbs_pkg::REG_DIST_MIN:   prdata = 32'(cfg_q.range_lo_mm);
      pbs_pkg::REG_DIST_MAX:   prdata = 32'(cfg_q.range_hi_mm);
      pbs_pkg::REG_DELAY_MIN:  prdata = 32'(cfg_q.delay_min_ms);
      pbs_pkg::REG_DELAY_MAX:  prdata = 32'(cfg_q.delay_max_ms);
      pbs_pkg::REG_BEEP_ON:    prdata = 32'(cfg_q.beep_len_ms);
      pbs_pkg::REG_OCTAVE_BND: prdata = 32'(cfg_q.band_width_mm);
      pbs_pkg::REG_FLUX_MIN:   prdata = 32'(cfg_q.flux_min);
      pbs_pkg::REG_BASE_FREQ:  prdata = 32'(cfg_q.base_freq_hz);
    endcase
  end

endmodule

/* rtl/core/pbs_div.sv */
// Shared restoring divider: one quotient bit per cycle, left-aligned dividend.
module pbs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbs_pkg::pbs_div_req_t req_i,
  output pbs_pkg::pbs_div_rsp_t rsp_o
);

  logic [pbs_pkg::DVD_W-1:0]  dvd_q;
  logic [pbs_pkg::DVD_W-1:0]  quo_q;
  logic [pbs_pkg::DVS_W-1:0]  dvs_q;
  logic [pbs_pkg::DVS_W-1:0]  rem_q;
  logic [pbs_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [pbs_pkg::DVS_W:0]    trial;
  logic                       ge;
  logic [pbs_pkg::DVS_W:0]    diff;
  logic [pbs_pkg::DVS_W-1:0]  rem_d;

  // remainder < divisor, so trial < 2*divisor and the new remainder fits
  assign trial = {rem_q, dvd_q[pbs_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[pbs_pkg::DVS_W-1:0] : trial[pbs_pkg::DVS_W-1:0];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == pbs_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[pbs_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[pbs_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/pbs_checker.sv */
// Port-level checker for the proximity beep sequencer, bound to the top level.
module pbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        tone_active_o,
  input logic [15:0] distance_mm_o,
  input logic [15:0] interval_ms_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(distance_mm_o) && $stable(interval_ms_o) && $stable(tone_active_o))
    else $error("result payload changed while stalled");

  // an accepted request raises in_stall_o in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready right after accepting a request");

  // finishing a request always leaves its result in the output register
  a_result_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("request finished without a result");

endmodule

bind proximity_beep_sequencer pbs_checker u_pbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tone_active_o (tone_active_o),
  .distance_mm_o (distance_mm_o),
  .interval_ms_o (interval_ms_o)
);
